@@ rtl/spq_pkg.sv @@
// shared types and constants for the stable priority queue
`default_nettype none

package spq_pkg;

  // default sizes
  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned TAG_BITS_DEF  = 16;
  localparam int unsigned PRIO_BITS_DEF = 8;

  // operation codes on the kind field
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert the broadcast item
    logic rem;  // shift everything one place towards the head
  } spq_op_t;

endpackage : spq_pkg

`default_nettype wire

@@ rtl/spq_cell.sv @@
// one slot of the sorted chain: holds an item and follows the broadcast command
`default_nettype none

module spq_cell #(
  parameter int unsigned TAG_BITS  = spq_pkg::TAG_BITS_DEF,
  parameter int unsigned PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  spq_pkg::spq_op_t      op,
  input  wire  [TAG_BITS-1:0]   new_tag,
  input  wire  [PRIO_BITS-1:0]  new_prio,
  // neighbour towards the head
  input  wire                   prev_valid,
  input  wire                   prev_keep,
  input  wire  [TAG_BITS-1:0]   prev_tag,
  input  wire  [PRIO_BITS-1:0]  prev_prio,
  // neighbour towards the tail
  input  wire                   next_valid,
  input  wire  [TAG_BITS-1:0]   next_tag,
  input  wire  [PRIO_BITS-1:0]  next_prio,
  // own contents
  output logic                  valid,
  output logic                  keep,
  output logic [TAG_BITS-1:0]   tag,
  output logic [PRIO_BITS-1:0]  prio
);

  logic                 valid_r, valid_nxt;
  logic [TAG_BITS-1:0]  tag_r, tag_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;

  // item stays put when it ranks equal or above the newcomer
  assign keep = valid_r && (prio_r >= new_prio);

  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    prio_nxt  = prio_r;
    priority if (op.rem) begin
      valid_nxt = next_valid;
      tag_nxt   = next_tag;
      prio_nxt  = next_prio;
    end else if (op.ins && !keep) begin
      if (prev_keep) begin
        valid_nxt = 1'b1;
        tag_nxt   = new_tag;
        prio_nxt  = new_prio;
      end else begin
        valid_nxt = prev_valid;
        tag_nxt   = prev_tag;
        prio_nxt  = prev_prio;
      end
    end else begin
      // contents hold
      valid_nxt = valid_r;
      tag_nxt   = tag_r;
      prio_nxt  = prio_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
  end

  assign valid = valid_r;
  assign tag   = tag_r;
  assign prio  = prio_r;

endmodule : spq_cell

`default_nettype wire

@@ rtl/stable_priority_queue_top.sv @@
// stable priority queue: a chain of sorted cells with a registered result word
// the result word is registered and becomes valid in the cycle after its input word is accepted
// throughput: one word per cycle while out_ready keeps the result register free, set by the update of the cell chain
// a full result register holds off input only while out_ready is low
// reset (synchronous, rst_n low) empties the queue and drops any pending result
// no clearing pass: cell valid bits reset at once, slot payloads need no reset
`default_nettype none

module stable_priority_queue_top #(
  parameter int unsigned DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int unsigned TAG_BITS  = spq_pkg::TAG_BITS_DEF,
  parameter int unsigned PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1)
) (
  input  wire                  clk,
  input  wire                  rst_n,
  // input channel
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  in_kind,
  input  wire  [TAG_BITS-1:0]  in_item_tag,
  input  wire  [PRIO_BITS-1:0] in_priority_req,
  // result channel
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [TAG_BITS-1:0]  out_tag,
  output logic [PRIO_BITS-1:0] out_priority,
  output logic [1:0]           out_status,
  output logic [CNT_W-1:0]     out_occupancy
);

  // ---------------------------------------------------------------------------
  // handshake and command decode
  // ---------------------------------------------------------------------------
  logic             out_valid_r;
  logic             accept;
  logic             full, empty;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  spq_pkg::spq_op_t op;

  // result register frees up in the same cycle it is taken
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);

  // refused operations leave the chain untouched
  assign op.ins = accept && (in_kind == spq_pkg::KIND_INSERT) && !full;
  assign op.rem = accept && (in_kind == spq_pkg::KIND_REMOVE) && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    priority if (op.ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (op.rem) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // ---------------------------------------------------------------------------
  // chain of cells, head at index 0
  // ---------------------------------------------------------------------------
  logic                 cell_valid [DEPTH];
  logic                 cell_keep  [DEPTH];
  logic [TAG_BITS-1:0]  cell_tag   [DEPTH];
  logic [PRIO_BITS-1:0] cell_prio  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 p_valid, p_keep, n_valid;
    logic [TAG_BITS-1:0]  p_tag, n_tag;
    logic [PRIO_BITS-1:0] p_prio, n_prio;

    if (i == 0) begin : g_head
      // nothing ranks above the head, so a newcomer lands here if it goes no further
      assign p_valid = 1'b0;
      assign p_keep  = 1'b1;
      assign p_tag   = '0;
      assign p_prio  = '0;
    end else begin : g_mid
      assign p_valid = cell_valid[i-1];
      assign p_keep  = cell_keep[i-1];
      assign p_tag   = cell_tag[i-1];
      assign p_prio  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // an empty slot shifts in behind the last cell on remove
      assign n_valid = 1'b0;
      assign n_tag   = '0;
      assign n_prio  = '0;
    end else begin : g_body
      assign n_valid = cell_valid[i+1];
      assign n_tag   = cell_tag[i+1];
      assign n_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .TAG_BITS  (TAG_BITS),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .new_tag    (in_item_tag),
      .new_prio   (in_priority_req),
      .prev_valid (p_valid),
      .prev_keep  (p_keep),
      .prev_tag   (p_tag),
      .prev_prio  (p_prio),
      .next_valid (n_valid),
      .next_tag   (n_tag),
      .next_prio  (n_prio),
      .valid      (cell_valid[i]),
      .keep       (cell_keep[i]),
      .tag        (cell_tag[i]),
      .prio       (cell_prio[i])
    );
  end

  // ---------------------------------------------------------------------------
  // result word
  // ---------------------------------------------------------------------------
  logic [TAG_BITS-1:0]  out_tag_r, out_tag_nxt;
  logic [PRIO_BITS-1:0] out_prio_r, out_prio_nxt;
  spq_pkg::spq_status_t out_status_r, out_status_nxt;
  logic [CNT_W-1:0]     out_occ_r;

  always_comb begin
    out_tag_nxt    = '0;
    out_prio_nxt   = '0;
    out_status_nxt = spq_pkg::ST_DONE;
    priority if (in_kind == spq_pkg::KIND_INSERT && full) begin
      out_status_nxt = spq_pkg::ST_FULL;
    end else if (in_kind == spq_pkg::KIND_REMOVE && empty) begin
      out_status_nxt = spq_pkg::ST_EMPTY;
    end else if (in_kind == spq_pkg::KIND_REMOVE) begin
      // head cell carries the highest, earliest item
      out_tag_nxt  = cell_tag[0];
      out_prio_nxt = cell_prio[0];
    end else begin
      // accepted insert carries a zero payload
      out_status_nxt = spq_pkg::ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload of the result word, loaded only on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      out_tag_r    <= out_tag_nxt;
      out_prio_r   <= out_prio_nxt;
      out_status_r <= out_status_nxt;
      out_occ_r    <= cnt_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tag       = out_tag_r;
  assign out_priority  = out_prio_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

endmodule : stable_priority_queue_top

`default_nettype wire

@@ rtl/spq_checker.sv @@
// port-level checks for the stable priority queue, bound to the top level
`default_nettype none

module spq_checker #(
  parameter int unsigned DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int unsigned TAG_BITS  = spq_pkg::TAG_BITS_DEF,
  parameter int unsigned PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1)
) (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire [TAG_BITS-1:0]  out_tag,
  input wire [PRIO_BITS-1:0] out_priority,
  input wire [1:0]           out_status,
  input wire [CNT_W-1:0]     out_occupancy
);

  // occupancy never exceeds capacity
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= CNT_W'(DEPTH)))
    else $error("occupancy above capacity");

  // refused insert only when full, with zero payload
  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == spq_pkg::ST_FULL) |->
      (out_occupancy == CNT_W'(DEPTH) && out_tag == '0 && out_priority == '0))
    else $error("full status with wrong word");

  // empty remove only when empty, with zero payload
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == spq_pkg::ST_EMPTY) |->
      (out_occupancy == '0 && out_tag == '0 && out_priority == '0))
    else $error("empty status with wrong word");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_tag) && $stable(out_priority) &&
       $stable(out_status) && $stable(out_occupancy)))
    else $error("result word changed while stalled");

endmodule : spq_checker

bind stable_priority_queue_top spq_checker #(
  .DEPTH     (DEPTH),
  .TAG_BITS  (TAG_BITS),
  .PRIO_BITS (PRIO_BITS)
) u_spq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_tag       (out_tag),
  .out_priority  (out_priority),
  .out_status    (out_status),
  .out_occupancy (out_occupancy)
);

`default_nettype wire

@@ test/tb_stable_priority_queue_top.sv @@
// self-checking testbench for the stable priority queue top level
module tb_stable_priority_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = spq_pkg::DEPTH_DEF;
  localparam int unsigned TAG_BITS    = spq_pkg::TAG_BITS_DEF;
  localparam int unsigned PRIO_BITS   = spq_pkg::PRIO_BITS_DEF;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned HOLD_CYCLES = 80;    // long receiver hold-off
  localparam int unsigned MAX_REPORTS = 10;    // mismatches printed in full
  localparam int unsigned DRAIN_LIMIT = 5000;  // cycles allowed for the last words
  localparam int unsigned TAIL_CYCLES = 8;     // quiet cycles after the last word

  // one expected result word
  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] prio;
    spq_pkg::spq_status_t status;
    logic [CNT_W-1:0]     occ;
  } queue_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_kind = spq_pkg::KIND_INSERT;
  logic [TAG_BITS-1:0]  in_item_tag = '0;
  logic [PRIO_BITS-1:0] in_priority_req = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [TAG_BITS-1:0]  out_tag;
  logic [PRIO_BITS-1:0] out_priority;
  logic [1:0]           out_status;
  logic [CNT_W-1:0]     out_occupancy;

  // predictor copy of the sorted slots, head at index 0
  logic [TAG_BITS-1:0]  model_tags [DEPTH];
  logic [PRIO_BITS-1:0] model_prios [DEPTH];
  int unsigned          model_count = 0;

  queue_result_t expected_results [$];
  int unsigned   error_count = 0;

  // shared idling controls
  bit          calm = 1'b0;      // no gaps on either side while set
  bit          hold_req = 1'b0;  // asks the receiver for a long hold-off
  int unsigned hold_left = 0;
  int unsigned rx_idle_left = 0;

  stable_priority_queue_top #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS),
    .PRIO_BITS(PRIO_BITS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_item_tag    (in_item_tag),
    .in_priority_req(in_priority_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tag        (out_tag),
    .out_priority   (out_priority),
    .out_status     (out_status),
    .out_occupancy  (out_occupancy)
  );

  always #2 clk = ~clk;

  // gap length: mostly none, often short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // stable sorted insert / head remove, one expected word per accepted input
  task automatic predict_queue_op(input logic kind, input logic [TAG_BITS-1:0] tag,
                                  input logic [PRIO_BITS-1:0] prio);
    queue_result_t res;
    int unsigned   pos;
    res = '0;
    res.status = spq_pkg::ST_DONE;
    if (kind == spq_pkg::KIND_INSERT) begin
      if (model_count >= DEPTH) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        // after every stored item of equal or higher priority
        pos = 0;
        while (pos < model_count && model_prios[pos] >= prio) pos++;
        for (int unsigned k = model_count; k > pos; k--) begin
          model_tags[k]  = model_tags[k-1];
          model_prios[k] = model_prios[k-1];
        end
        model_tags[pos]  = tag;
        model_prios[pos] = prio;
        model_count++;
      end
    end else if (model_count == 0) begin
      res.status = spq_pkg::ST_EMPTY;
    end else begin
      res.tag  = model_tags[0];
      res.prio = model_prios[0];
      for (int unsigned k = 1; k < model_count; k++) begin
        model_tags[k-1]  = model_tags[k];
        model_prios[k-1] = model_prios[k];
      end
      model_count--;
    end
    res.occ = model_count[CNT_W-1:0];
    expected_results.push_back(res);
  endtask

  // offer one word from a falling edge, return at the falling edge after acceptance
  task automatic send_word(input logic kind, input logic [TAG_BITS-1:0] tag,
                           input logic [PRIO_BITS-1:0] prio);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_kind         = kind;
    in_item_tag     = tag;
    in_priority_req = prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_queue_op(kind, tag, prio);
    @(negedge clk);
  endtask

  // random stream; ties squeezes priorities onto four levels including both extremes
  task automatic run_random(input int unsigned n, input int unsigned insert_pct,
                            input bit ties);
    logic                 kind;
    logic [PRIO_BITS-1:0] prio;
    for (int unsigned i = 0; i < n; i++) begin
      kind = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::KIND_INSERT
                                                   : spq_pkg::KIND_REMOVE;
      if (ties) begin
        prio = PRIO_BITS'($urandom_range(0, 3) * 85);
      end else begin
        prio = PRIO_BITS'($urandom);
      end
      send_word(kind, TAG_BITS'($urandom), prio);
    end
  endtask

  // remove straight after reset, with junk in the ignored fields
  task automatic test_remove_when_empty();
    send_word(spq_pkg::KIND_REMOVE, '1, '1);
  endtask

  // fill every slot with extreme tags and priorities, ties among them, then one refused insert
  task automatic test_fill_to_full();
    logic [PRIO_BITS-1:0] prio_pattern [16];
    logic [TAG_BITS-1:0]  tag;
    prio_pattern = '{8'd0, 8'd255, 8'd128, 8'd128, 8'd255, 8'd1, 8'd0, 8'd128,
                     8'd254, 8'd7, 8'd128, 8'd255, 8'd0, 8'd64, 8'd64, 8'd200};
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        tag = '0;
      end else if (i == DEPTH - 1) begin
        tag = '1;
      end else begin
        tag = TAG_BITS'($urandom);
      end
      send_word(spq_pkg::KIND_INSERT, tag, prio_pattern[i % 16]);
    end
    send_word(spq_pkg::KIND_INSERT, TAG_BITS'($urandom), '1);
  endtask

  // take a few head items; equal priorities must come out in arrival order
  task automatic test_head_removal();
    repeat (4) send_word(spq_pkg::KIND_REMOVE, TAG_BITS'($urandom), PRIO_BITS'($urandom));
  endtask

  // insert-heavy stream keeps the queue near full and provokes refusals
  task automatic test_insert_heavy_mix();
    run_random(150, 75, 1'b0);
  endtask

  // remove-heavy stream empties the queue often
  task automatic test_remove_heavy_mix();
    run_random(150, 25, 1'b0);
  endtask

  // few priority levels so that ordering among equals dominates
  task automatic test_equal_priority_ties();
    run_random(150, 55, 1'b1);
  endtask

  // back-to-back words with no gaps on either side
  task automatic test_back_to_back();
    calm = 1'b1;
    run_random(120, 50, 1'b1);
    calm = 1'b0;
  endtask

  // receiver stops for a long stretch while words keep coming
  task automatic test_output_hold_off();
    hold_req = 1'b1;
    run_random(60, 60, 1'b0);
  endtask

  // receiver: random ready with gaps, plus the long hold-off on request
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      out_ready = 1'b0;
      hold_left--;
      if (hold_left == 0) begin
        hold_req = 1'b0;
      end
    end else if (rx_idle_left != 0) begin
      out_ready = 1'b0;
      rx_idle_left--;
    end else begin
      out_ready = 1'b1;
      rx_idle_left = pick_gap();
    end
  end

  // result checker: every accepted word against the oldest expectation
  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        if (error_count < MAX_REPORTS) begin
          $display("unexpected result word: tag %h prio %h status %0d occ %0d",
                   out_tag, out_priority, out_status, out_occupancy);
        end
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tag !== want.tag || out_priority !== want.prio ||
            out_status !== want.status || out_occupancy !== want.occ) begin
          if (error_count < MAX_REPORTS) begin
            $display("mismatch: tag %h/%h prio %h/%h status %0d/%0d occ %0d/%0d (exp/act)",
                     want.tag, out_tag, want.prio, out_priority,
                     want.status, out_status, want.occ, out_occupancy);
          end
          error_count++;
        end
      end
    end
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb_stable_priority_queue_top: done, errors");
    $finish;
  end

  initial begin
    int unsigned drain_wait;
    // single reset at start of run, released on a falling edge
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed part
    test_remove_when_empty();
    test_fill_to_full();
    test_head_removal();

    // random part
    test_insert_heavy_mix();
    test_remove_heavy_mix();
    test_equal_priority_ties();
    test_back_to_back();
    test_output_hold_off();

    in_valid = 1'b0;

    // let the last words through, then a few quiet cycles
    drain_wait = 0;
    while (expected_results.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    // anything still waiting never arrived
    error_count += expected_results.size();

    if (error_count == 0) begin
      $display("tb_stable_priority_queue_top: done, clean");
    end else begin
      $display("tb_stable_priority_queue_top: done, errors");
    end
    $finish;
  end

endmodule
